[rtl/core/sida_pkg.sv]
// Shared types and constants for the signed integer to decimal text converter.
`timescale 1ns / 1ps

package sida_pkg;

  localparam int MAG_W       = 32;
  localparam int BIT_CNT_W   = $clog2(MAG_W);
  localparam int FULL_DIGITS = 10;
  localparam int MAX_DIGITS  = 10;
  localparam int LIMIT       = (MAX_DIGITS < FULL_DIGITS) ? MAX_DIGITS : FULL_DIGITS;
  localparam int CNT_W       = $clog2(FULL_DIGITS + 1);
  localparam int IDX_W       = $clog2(FULL_DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } chain_ctrl_t;

  typedef logic [FULL_DIGITS-1:0][3:0] digits_t;

endpackage

[rtl/core/sida_cell.sv]
// One BCD digit cell of the shift-and-add-3 conversion chain.
`timescale 1ns / 1ps

module sida_cell (
  input  logic                 clk,
  input  sida_pkg::chain_ctrl_t ctrl,
  input  logic                 bit_in,
  output logic                 bit_out,
  output logic [3:0]           digit
);

  logic [3:0] adjusted;

  // A digit of five or more overflows on the next doubling, so add three first.
  assign adjusted = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign bit_out  = adjusted[3];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.shift) begin
      digit <= {adjusted[2:0], bit_in};
    end
  end

endmodule

[rtl/core/sida_chain.sv]
// Row of BCD digit cells; the binary magnitude enters bit by bit at the low end.
`timescale 1ns / 1ps

module sida_chain (
  input  logic                  clk,
  input  sida_pkg::chain_ctrl_t ctrl,
  input  logic                  serial_in,
  output sida_pkg::digits_t     digits
);

  logic [sida_pkg::FULL_DIGITS:0] carry;

  assign carry[0] = serial_in;

  for (genvar i = 0; i < sida_pkg::FULL_DIGITS; i++) begin : g_cell
    sida_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .bit_in (carry[i]),
      .bit_out(carry[i+1]),
      .digit  (digits[i])
    );
  end

  // The top cell never overflows for a 32-bit magnitude; its carry is dropped.
  logic unused_carry;
  assign unused_carry = carry[sida_pkg::FULL_DIGITS];

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII character stream.
`timescale 1ns / 1ps

// Usage
// The value channel takes one signed 32-bit word when value_valid is high and
// value_stall is low. The character channel returns the decimal text of that
// word, one ASCII character at a time, most significant first, with last set
// on the final character. Zero gives '0' alone; any other value gives a sign
// ('+' or '-') followed by its digits without leading zeros.
// A nonzero word is converted by a row of ten BCD digit cells that takes one
// magnitude bit per cycle in the convert state, and its first character is
// offered once the emit state is reached; a zero is answered in the following
// cycle. Characters then follow one per cycle while the receiver takes them.
// One word is handled at a time, and value_stall is high from acceptance until
// the last character has been taken.
// While character_stall is high the offered character and last hold steady.
// Synchronous reset returns the block to idle and drops any word in progress.

module signed_int_to_decimal_ascii (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] value,
  input  logic               value_valid,
  output logic               value_stall,
  output logic [7:0]         character,
  output logic               last,
  output logic               character_valid,
  input  logic               character_stall
);

  sida_pkg::state_t state;
  sida_pkg::state_t state_next;

  logic [sida_pkg::MAG_W-1:0]     mag;
  logic [sida_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic                           negative;
  logic                           zero;
  logic                           is_min;
  logic                           sign_pending;
  logic [sida_pkg::IDX_W-1:0]     idx;

  sida_pkg::chain_ctrl_t          chain_ctrl;
  sida_pkg::digits_t              digits;
  logic [sida_pkg::CNT_W-1:0]     ndigits;
  logic [sida_pkg::CNT_W-1:0]     count;

  logic                           in_accept;
  logic                           out_accept;
  logic [sida_pkg::MAG_W-1:0]     value_u;

  assign in_accept  = value_valid && !value_stall;
  assign out_accept = character_valid && !character_stall;
  assign value_u    = unsigned'(value);

  sida_chain u_chain (
    .clk      (clk),
    .ctrl     (chain_ctrl),
    .serial_in(mag[sida_pkg::MAG_W-1]),
    .digits   (digits)
  );

  // Number of significant digits held by the chain.
  always_comb begin
    ndigits = '0;
    for (int i = 0; i < sida_pkg::FULL_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        ndigits = sida_pkg::CNT_W'(i + 1);
      end
    end
  end

  // The most negative value always keeps all ten digits.
  always_comb begin
    if (is_min) begin
      count = sida_pkg::CNT_W'(sida_pkg::FULL_DIGITS);
    end else if (ndigits > sida_pkg::CNT_W'(sida_pkg::LIMIT)) begin
      count = sida_pkg::CNT_W'(sida_pkg::LIMIT);
    end else begin
      count = ndigits;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sida_pkg::ST_IDLE: begin
        if (value_valid) begin
          state_next = (value_u == '0) ? sida_pkg::ST_EMIT : sida_pkg::ST_CONVERT;
        end
      end
      sida_pkg::ST_CONVERT: begin
        if (bit_cnt == sida_pkg::BIT_CNT_W'(sida_pkg::MAG_W - 1)) begin
          state_next = sida_pkg::ST_EMIT;
        end
      end
      sida_pkg::ST_EMIT: begin
        if (!character_stall && last) begin
          state_next = sida_pkg::ST_IDLE;
        end
      end
      default: state_next = sida_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    value_stall      = 1'b1;
    character_valid  = 1'b0;
    character        = sida_pkg::CHAR_ZERO;
    last             = 1'b0;
    chain_ctrl.clear = 1'b0;
    chain_ctrl.shift = 1'b0;
    case (state)
      sida_pkg::ST_IDLE: begin
        value_stall      = 1'b0;
        chain_ctrl.clear = value_valid;
      end
      sida_pkg::ST_CONVERT: begin
        chain_ctrl.shift = 1'b1;
      end
      sida_pkg::ST_EMIT: begin
        character_valid = 1'b1;
        if (zero) begin
          character = sida_pkg::CHAR_ZERO;
          last      = 1'b1;
        end else if (sign_pending) begin
          character = negative ? sida_pkg::CHAR_MINUS : sida_pkg::CHAR_PLUS;
          last      = (count == '0);
        end else begin
          character = sida_pkg::CHAR_ZERO + {4'd0, digits[idx]};
          last      = (idx == '0);
        end
      end
      default: begin
        value_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sida_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      negative     <= value_u[sida_pkg::MAG_W-1];
      zero         <= (value_u == '0);
      is_min       <= (value_u == {1'b1, {(sida_pkg::MAG_W-1){1'b0}}});
      mag          <= value_u[sida_pkg::MAG_W-1] ? (~value_u + 1'b1) : value_u;
      bit_cnt      <= '0;
      sign_pending <= 1'b1;
      idx          <= '0;
    end else if (state == sida_pkg::ST_CONVERT) begin
      mag     <= {mag[sida_pkg::MAG_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
    end else if (out_accept) begin
      if (sign_pending) begin
        sign_pending <= 1'b0;
        idx          <= sida_pkg::IDX_W'(count - 1'b1);
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == sida_pkg::ST_EMIT && !zero && !sign_pending) |->
      (sida_pkg::CNT_W'(idx) < count))
    else $error("digit index beyond the significant digits");

  a_nonzero_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == sida_pkg::ST_EMIT && !zero) |-> (count != '0))
    else $error("nonzero word converted to no digits");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_accept && last) |=> (state == sida_pkg::ST_IDLE))
    else $error("block not idle after the final character");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != sida_pkg::ST_IDLE))
    else $error("accepted word did not start a conversion");

  a_convert_length: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == sida_pkg::ST_CONVERT && state == sida_pkg::ST_EMIT) |->
      (bit_cnt == '0))
    else $error("conversion ended before all magnitude bits were shifted");

endmodule
